// File: rtl/hln_pkg.sv
`default_nettype none

package hln_pkg;

  localparam logic [7:0] ChCr  = 8'h0D;
  localparam logic [7:0] ChLf  = 8'h0A;
  localparam logic [7:0] ChSp  = 8'h20;
  localparam logic [7:0] ChTab = 8'h09;

  // Lookahead phase: a CR is held, or a newline waits for its fold check.
  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_CR   = 2'd1,
    PH_LF   = 2'd2
  } hln_phase_e;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       end_marker;
    logic       last_of_run;
  } hln_res_t;

  // Everything one input word produces: up to two results and the next state.
  typedef struct packed {
    logic [1:0]      cnt;
    hln_res_t [1:0]  res;
    hln_phase_e      phase;
    logic            lwn;
  } hln_step_t;

endpackage

`default_nettype wire

// File: rtl/hln_step.sv
`default_nettype none

module hln_step import hln_pkg::*; (
  input  var logic [7:0]  byte_i,
  input  var logic        eoi_i,
  input  var hln_phase_e  phase_i,
  input  var logic        lwn_i,
  output hln_step_t       step_o
);

  function automatic hln_step_t push(hln_step_t s, logic [7:0] b, logic endm);
    hln_step_t t;
    t = s;
    t.res[s.cnt[0]].out_byte    = b;
    t.res[s.cnt[0]].end_marker  = endm;
    t.res[s.cnt[0]].last_of_run = 1'b0;
    t.cnt = s.cnt + 2'd1;
    return t;
  endfunction

  // A newline is known: emit it now if the last output was already a newline,
  // otherwise hold it for the fold check against the next byte.
  function automatic hln_step_t resolve(hln_step_t s);
    hln_step_t t;
    t = s;
    if (s.lwn) begin
      t.phase = PH_IDLE;
      t = push(t, ChLf, 1'b0);
    end else begin
      t.phase = PH_LF;
    end
    return t;
  endfunction

  function automatic hln_step_t fresh(hln_step_t s, logic [7:0] b);
    hln_step_t t;
    t = s;
    if (b == ChCr) begin
      t.phase = PH_CR;
    end else if (b == ChLf) begin
      t = resolve(t);
    end else begin
      t.phase = PH_IDLE;
      t.lwn   = 1'b0;
      t = push(t, b, 1'b0);
    end
    return t;
  endfunction

  function automatic hln_step_t fold(hln_step_t s, logic [7:0] b);
    hln_step_t t;
    t = s;
    if (!s.lwn && (b == ChSp || b == ChTab)) begin
      t.phase = PH_IDLE;
      t.lwn   = 1'b0;
      t = push(t, ChSp, 1'b0);
    end else begin
      t = push(t, ChLf, 1'b0);
      t.lwn   = 1'b1;
      t.phase = PH_IDLE;
      t = fresh(t, b);
    end
    return t;
  endfunction

  always_comb begin
    hln_step_t s;
    s       = '0;
    s.phase = PH_IDLE;
    s.lwn   = lwn_i;
    if (eoi_i) begin
      if (phase_i == PH_CR || phase_i == PH_LF) begin
        s = push(s, ChLf, 1'b0);
      end
      s = push(s, 8'h00, 1'b1);
      s.phase = PH_IDLE;
      s.lwn   = 1'b0;
    end else begin
      unique case (phase_i)
        PH_CR: begin
          if (byte_i == ChLf) begin
            s = resolve(s);
          end else begin
            s = fold(s, byte_i);
          end
        end
        PH_LF:   s = fold(s, byte_i);
        default: s = fresh(s, byte_i);
      endcase
    end
    if (s.cnt == 2'd2) begin
      s.res[1].last_of_run = 1'b1;
    end else if (s.cnt == 2'd1) begin
      s.res[0].last_of_run = 1'b1;
    end
    step_o = s;
  end

endmodule

`default_nettype wire

// File: rtl/hln_out_q.sv
`default_nettype none

module hln_out_q import hln_pkg::*; (
  input  var logic             clk_i,
  input  var logic             rst_ni,
  input  var logic             push_i,
  input  var logic [1:0]       push_cnt_i,
  input  var hln_res_t [1:0]   push_res_i,
  output logic                 empty_next_o,
  output logic                 valid_o,
  input  var logic             stall_i,
  output hln_res_t             res_o
);

  logic [1:0]     cnt_q, cnt_d;
  hln_res_t [1:0] slot_q, slot_d;
  logic           pop;

  assign valid_o = (cnt_q != 2'd0);
  assign pop     = valid_o && !stall_i;
  assign res_o   = slot_q[0];

  // Room for a full two-word burst exists when the queue is empty or its only word leaves this cycle.
  assign empty_next_o = (cnt_q == 2'd0) || (cnt_q == 2'd1 && pop);

  always_comb begin
    cnt_d  = cnt_q;
    slot_d = slot_q;
    if (push_i) begin
      cnt_d  = push_cnt_i;
      slot_d = push_res_i;
    end else if (pop) begin
      cnt_d     = cnt_q - 2'd1;
      slot_d[0] = slot_q[1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
  end

endmodule

`default_nettype wire

// File: rtl/http_line_ending_normalizer.sv
`default_nettype none

// Channel | Direction | Handshake              | Word
// input   | in        | in_valid_i / in_stall_o   | in_byte_i, end_of_input_i
// output  | out       | out_valid_o / out_stall_i | out_byte_o, end_marker_o, last_of_run_o
//
// One input word is taken per cycle while in_stall_o is low; it is held in the input register,
// and its results are registered in the output queue. A word that yields two results fills
// both queue slots, and the input side stalls while both are held.
// Reset clears the input register, the lookahead phase and the output queue.
// Input words wait in the input register while the output queue lacks room for two results.

module http_line_ending_normalizer import hln_pkg::*; (
  input  var logic       clk_i,
  input  var logic       rst_ni,
  input  var logic       in_valid_i,
  output logic           in_stall_o,
  input  var logic [7:0] in_byte_i,
  input  var logic       end_of_input_i,
  output logic           out_valid_o,
  input  var logic       out_stall_i,
  output logic [7:0]     out_byte_o,
  output logic           end_marker_o,
  output logic           last_of_run_o
);

  logic       in_vld_q;
  logic [7:0] byte_q;
  logic       eoi_q;
  hln_phase_e phase_q, phase_d;
  logic       lwn_q, lwn_d;
  logic       room;
  logic       proc;
  hln_step_t  step;
  hln_res_t   res;

  assign proc       = in_vld_q && room;
  assign in_stall_o = in_vld_q && !room;

  hln_step u_step (
    .byte_i  (byte_q),
    .eoi_i   (eoi_q),
    .phase_i (phase_q),
    .lwn_i   (lwn_q),
    .step_o  (step)
  );

  assign phase_d = proc ? step.phase : phase_q;
  assign lwn_d   = proc ? step.lwn   : lwn_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      phase_q  <= PH_IDLE;
      lwn_q    <= 1'b0;
    end else begin
      if (!in_stall_o) begin
        in_vld_q <= in_valid_i;
      end
      phase_q <= phase_d;
      lwn_q   <= lwn_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      byte_q <= in_byte_i;
      eoi_q  <= end_of_input_i;
    end
  end

  hln_out_q u_out_q (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (proc),
    .push_cnt_i   (step.cnt),
    .push_res_i   (step.res),
    .empty_next_o (room),
    .valid_o      (out_valid_o),
    .stall_i      (out_stall_i),
    .res_o        (res)
  );

  assign out_byte_o    = res.out_byte;
  assign end_marker_o  = res.end_marker;
  assign last_of_run_o = res.last_of_run;

endmodule

`default_nettype wire

// File: test/tb_top.sv
`default_nettype none

// Scoreboard: predicts the normalised stream from every accepted input word and
// checks each delivered output word against the oldest prediction.
class line_norm_board;
  hln_pkg::hln_phase_e phase;
  logic lwn;
  hln_pkg::hln_res_t run[$];
  hln_pkg::hln_res_t expected_q[$];
  int words;
  int eoi_words;
  int folds;
  int checked;
  int errors;

  function new();
    phase = hln_pkg::PH_IDLE;
    lwn = 1'b0;
    words = 0;
    eoi_words = 0;
    folds = 0;
    checked = 0;
    errors = 0;
  endfunction

  function void emit(logic [7:0] b, logic em);
    hln_pkg::hln_res_t r;
    r.out_byte = b;
    r.end_marker = em;
    r.last_of_run = 1'b0;
    run.push_back(r);
  endfunction

  // A newline right after another newline cannot fold, so it goes out at once.
  function void settle_newline();
    if (lwn) begin
      phase = hln_pkg::PH_IDLE;
      emit(hln_pkg::ChLf, 1'b0);
    end else begin
      phase = hln_pkg::PH_LF;
    end
  endfunction

  function void plain_byte(logic [7:0] b);
    if (b == hln_pkg::ChCr) begin
      phase = hln_pkg::PH_CR;
    end else if (b == hln_pkg::ChLf) begin
      settle_newline();
    end else begin
      phase = hln_pkg::PH_IDLE;
      lwn = 1'b0;
      emit(b, 1'b0);
    end
  endfunction

  // The held newline meets its lookahead byte; an unfolded byte is handled afresh.
  function void try_fold(logic [7:0] b);
    if (!lwn && (b == hln_pkg::ChSp || b == hln_pkg::ChTab)) begin
      phase = hln_pkg::PH_IDLE;
      lwn = 1'b0;
      folds++;
      emit(hln_pkg::ChSp, 1'b0);
    end else begin
      emit(hln_pkg::ChLf, 1'b0);
      lwn = 1'b1;
      phase = hln_pkg::PH_IDLE;
      plain_byte(b);
    end
  endfunction

  function void note_word(logic [7:0] b, logic e);
    run.delete();
    words++;
    if (e) begin
      eoi_words++;
      if (phase == hln_pkg::PH_CR || phase == hln_pkg::PH_LF) begin
        emit(hln_pkg::ChLf, 1'b0);
      end
      emit(8'h00, 1'b1);
      phase = hln_pkg::PH_IDLE;
      lwn = 1'b0;
    end else begin
      case (phase)
        hln_pkg::PH_CR: begin
          if (b == hln_pkg::ChLf) settle_newline();
          else try_fold(b);
        end
        hln_pkg::PH_LF: try_fold(b);
        default: plain_byte(b);
      endcase
    end
    if (run.size() > 0) run[run.size() - 1].last_of_run = 1'b1;
    foreach (run[i]) expected_q.push_back(run[i]);
  endfunction

  function void check_result(logic [7:0] b, logic em, logic last);
    hln_pkg::hln_res_t want;
    checked++;
    if (expected_q.size() == 0) begin
      $display("%0t: output word with nothing expected: byte %h end %b last %b",
               $time, b, em, last);
      errors++;
      return;
    end
    want = expected_q.pop_front();
    if (want.out_byte !== b) begin
      $display("%0t: out_byte expected %h, got %h", $time, want.out_byte, b);
      errors++;
    end
    if (want.end_marker !== em) begin
      $display("%0t: end_marker expected %b, got %b", $time, want.end_marker, em);
      errors++;
    end
    if (want.last_of_run !== last) begin
      $display("%0t: last_of_run expected %b, got %b", $time, want.last_of_run, last);
      errors++;
    end
  endfunction
endclass

module tb_top;
  import hln_pkg::*;

  localparam int NumRandom = 1800;
  localparam int WatchLimit = 1000;
  localparam int HoldCycles = 120;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic [7:0] in_byte;
  logic in_end;
  logic out_valid;
  logic out_stall;
  logic [7:0] out_byte;
  logic out_end;
  logic out_last;

  line_norm_board board = new();
  int idle_cycles = 0;
  int in_calm = 0;
  int out_calm = 0;
  bit hold_done = 1'b0;

  // Directed words as {end_of_input, byte}.
  logic [8:0] directed [25] = '{
    {1'b0, 8'h41}, {1'b0, ChCr}, {1'b0, ChLf}, {1'b0, 8'h42}, {1'b0, ChCr},
    {1'b0, 8'h78}, {1'b0, ChLf}, {1'b0, ChSp}, {1'b0, ChCr}, {1'b0, ChTab},
    {1'b0, ChLf}, {1'b0, ChLf}, {1'b0, ChSp}, {1'b0, ChCr}, {1'b0, ChCr},
    {1'b1, 8'hFF}, {1'b0, 8'h00}, {1'b0, 8'hFF}, {1'b0, ChLf}, {1'b1, 8'h00},
    {1'b1, 8'h5A}, {1'b0, ChCr}, {1'b0, ChLf}, {1'b0, ChLf}, {1'b0, ChTab}
  };

  always #4 clk = ~clk;

  http_line_ending_normalizer DUT (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .in_byte_i      (in_byte),
    .end_of_input_i (in_end),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .out_byte_o     (out_byte),
    .end_marker_o   (out_end),
    .last_of_run_o  (out_last)
  );

  function automatic int draw_gap(ref int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 7) == 0) calm = $urandom_range(10, 40);
    return $urandom_range(0, 5);
  endfunction

  task automatic send_word(input logic [7:0] b, input logic e);
    int gap;
    gap = draw_gap(in_calm);
    repeat (gap) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte <= b;
    in_end <= e;
    do @(posedge clk); while (in_stall);
    board.note_word(b, e);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      board.check_result(out_byte, out_end, out_last);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WatchLimit) begin
      $display("%0t: no word moved for %0d cycles", $time, WatchLimit);
      $display("FAIL");
      $finish;
    end
  end

  // Receiver: random stalls, plus one long hold so that the block backs up.
  initial begin
    int n;
    out_stall <= 1'b0;
    @(posedge rst_n);
    forever begin
      if (!hold_done && board.checked >= 400) begin
        hold_done = 1'b1;
        n = HoldCycles;
      end else begin
        n = draw_gap(out_calm);
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    int k;
    logic [7:0] b;
    logic e;
    in_valid <= 1'b0;
    in_byte <= 8'h00;
    in_end <= 1'b0;
    rst_n <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) send_word(directed[i][7:0], directed[i][8]);

    // Mostly header-like text with plenty of line breaks and folds, some noise.
    repeat (NumRandom) begin
      k = $urandom_range(0, 99);
      e = 1'b0;
      if (k < 38) b = 8'($urandom_range(8'h21, 8'h7E));
      else if (k < 48) b = ChSp;
      else if (k < 55) b = ChTab;
      else if (k < 69) b = ChCr;
      else if (k < 83) b = ChLf;
      else if (k < 96) b = 8'($urandom_range(0, 255));
      else begin
        b = 8'($urandom_range(0, 255));
        e = 1'b1;
      end
      send_word(b, e);
    end
    in_valid <= 1'b0;

    while (board.expected_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Run covered %0d input words, %0d of them end-of-stream, and %0d folds.",
             board.words, board.eoi_words, board.folds);
    $display("%0d output words checked, %0d mismatches.", board.checked, board.errors);
    if (board.errors == 0 && board.expected_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule

`default_nettype wire
